// ===== rtl/json_token_scanner_top_macros.svh =====
`ifndef JSON_TOKEN_SCANNER_TOP_MACROS_SVH
`define JSON_TOKEN_SCANNER_TOP_MACROS_SVH

// checks sampled on clk, off while in reset
`define JTS_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`define JTS_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/jts_pkg.sv =====
`default_nettype none

package jts_pkg;

    localparam int LENGTH_BITS = 16;
    localparam int LINE_BITS   = 24;
    localparam int ERR_BITS    = 3;
    localparam int KIND_BITS   = 4;
    localparam int DATA_W      = LINE_BITS + 2 * LENGTH_BITS + ERR_BITS;
    localparam int TDATA_W     = ((DATA_W + 7) / 8) * 8;
    localparam int QDEPTH      = 4;
    localparam int QPTR_BITS   = $clog2(QDEPTH);

    localparam logic [KIND_BITS-1:0] KIND_LBRACKET   = 4'd0;
    localparam logic [KIND_BITS-1:0] KIND_RBRACKET   = 4'd1;
    localparam logic [KIND_BITS-1:0] KIND_LBRACE     = 4'd2;
    localparam logic [KIND_BITS-1:0] KIND_RBRACE     = 4'd3;
    localparam logic [KIND_BITS-1:0] KIND_COLON      = 4'd4;
    localparam logic [KIND_BITS-1:0] KIND_COMMA      = 4'd5;
    localparam logic [KIND_BITS-1:0] KIND_STRING     = 4'd6;
    localparam logic [KIND_BITS-1:0] KIND_NUMBER     = 4'd7;
    localparam logic [KIND_BITS-1:0] KIND_TRUE       = 4'd8;
    localparam logic [KIND_BITS-1:0] KIND_FALSE      = 4'd9;
    localparam logic [KIND_BITS-1:0] KIND_NULL       = 4'd10;
    localparam logic [KIND_BITS-1:0] KIND_WHITESPACE = 4'd11;
    localparam logic [KIND_BITS-1:0] KIND_END        = 4'd12;
    localparam logic [KIND_BITS-1:0] KIND_ERROR      = 4'd13;

    localparam logic [ERR_BITS-1:0] ERR_NONE          = 3'd0;
    localparam logic [ERR_BITS-1:0] ERR_END_IN_STRING = 3'd1;
    localparam logic [ERR_BITS-1:0] ERR_NO_INT_DIGIT  = 3'd2;
    localparam logic [ERR_BITS-1:0] ERR_NO_FRAC_DIGIT = 3'd3;
    localparam logic [ERR_BITS-1:0] ERR_NO_EXP_DIGIT  = 3'd4;
    localparam logic [ERR_BITS-1:0] ERR_UNKNOWN_WORD  = 3'd5;
    localparam logic [ERR_BITS-1:0] ERR_UNEXPECTED    = 3'd6;

    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_LOWER_E   = 8'h65;
    localparam logic [7:0] CH_UPPER_E   = 8'h45;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;

    localparam logic [1:0] WORD_TRUE  = 2'd0;
    localparam logic [1:0] WORD_FALSE = 2'd1;
    localparam logic [1:0] WORD_NULL  = 2'd2;

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_WS,
        MODE_STR,
        MODE_STR_ESC,
        MODE_MINUS,
        MODE_ZERO,
        MODE_INT,
        MODE_DOT,
        MODE_FRAC,
        MODE_EXP_MARK,
        MODE_EXP_SIGN,
        MODE_EXP,
        MODE_WORD,
        MODE_DONE
    } mode_t;

    typedef struct packed {
        logic [KIND_BITS-1:0]   kind;
        logic [LINE_BITS-1:0]   line;
        logic [LENGTH_BITS-1:0] column;
        logic [LENGTH_BITS-1:0] length;
        logic [ERR_BITS-1:0]    err;
    } token_t;

    typedef struct packed {
        logic   two;
        token_t t0;
        token_t t1;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    function automatic token_t mk_tok(
        input logic [KIND_BITS-1:0]   kind,
        input logic [LINE_BITS-1:0]   line,
        input logic [LENGTH_BITS-1:0] column,
        input logic [LENGTH_BITS-1:0] length,
        input logic [ERR_BITS-1:0]    err
    );
        token_t t;
        t.kind   = kind;
        t.line   = line;
        t.column = column;
        t.length = length;
        t.err    = err;
        return t;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    function automatic logic [2:0] word_len(input logic [1:0] w);
        logic [2:0] n;
        unique case (w)
            WORD_FALSE: n = 3'd5;
            default:    n = 3'd4;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] word_char(input logic [1:0] w, input logic [2:0] idx);
        logic [7:0] c;
        unique case ({w, idx})
            {WORD_TRUE,  3'd0}: c = 8'h74;
            {WORD_TRUE,  3'd1}: c = 8'h72;
            {WORD_TRUE,  3'd2}: c = 8'h75;
            {WORD_TRUE,  3'd3}: c = 8'h65;
            {WORD_FALSE, 3'd0}: c = 8'h66;
            {WORD_FALSE, 3'd1}: c = 8'h61;
            {WORD_FALSE, 3'd2}: c = 8'h6C;
            {WORD_FALSE, 3'd3}: c = 8'h73;
            {WORD_FALSE, 3'd4}: c = 8'h65;
            {WORD_NULL,  3'd0}: c = 8'h6E;
            {WORD_NULL,  3'd1}: c = 8'h75;
            {WORD_NULL,  3'd2}: c = 8'h6C;
            {WORD_NULL,  3'd3}: c = 8'h6C;
            default:            c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/json_token_scanner_top.sv =====
// path: a token is written into the queue when the beat that closes it is accepted, then registered in the output stage
// throughput: one text beat per cycle while the four-entry queue has room
// the output stage sends one token per cycle while m_axis_tready is high; a beat may cause two tokens
// reset: rst_n clears all scanner state asynchronously, emit_whitespace to 0
`default_nettype none
`include "json_token_scanner_top_macros.svh"

module json_token_scanner_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic                         cfg_wdata,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [7:0]                   s_axis_tdata,   // text_byte
    input  wire logic                         s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // start_line, start_column, token_length, error_code
    output logic [jts_pkg::TDATA_W-1:0]       m_axis_tdata,
    output logic [jts_pkg::KIND_BITS-1:0]     m_axis_tuser,   // token_kind
    output logic                              m_axis_tlast
);
    import jts_pkg::*;

    queue_stat_t q_stat;
    logic        q_push;
    logic        q_pop;
    entry_t      q_entry;
    entry_t      q_head;
    logic        out_valid;
    token_t      out_tok;
    logic        out_last;

    jts_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_stat        (q_stat),
        .q_push        (q_push),
        .q_entry       (q_entry)
    );

    jts_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .stat       (q_stat)
    );

    jts_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .q_stat    (q_stat),
        .pop       (q_pop),
        .out_ready (m_axis_tready),
        .out_valid (out_valid),
        .out_tok   (out_tok),
        .out_last  (out_last)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tuser  = out_tok.kind;
    assign m_axis_tlast  = out_last;
    assign m_axis_tdata  = TDATA_W'({out_tok.err, out_tok.length, out_tok.column, out_tok.line});

    `JTS_ASSERT_NEVER(a_push_full, q_push && q_stat.full, "token beat pushed into full queue")
    `JTS_ASSERT_NEVER(a_pop_empty, q_pop && q_stat.empty, "pop from empty queue")
    `JTS_ASSERT_IMPLIES(a_err_code, out_valid && (out_tok.kind == KIND_ERROR), out_tok.err != ERR_NONE, "error token without code")
    `JTS_ASSERT_IMPLIES(a_no_code, out_valid && (out_tok.kind != KIND_ERROR), out_tok.err == ERR_NONE, "error code on plain token")

endmodule

`default_nettype wire

// ===== rtl/jts_front.sv =====
`default_nettype none

module jts_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic                cfg_wdata,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [7:0]          s_axis_tdata,
    input  wire logic                s_axis_tlast,
    input  wire jts_pkg::queue_stat_t q_stat,
    output logic                     q_push,
    output jts_pkg::entry_t          q_entry
);
    import jts_pkg::*;

    mode_t                  mode_reg, mode_next;
    logic [LINE_BITS-1:0]   cur_line_reg, cur_line_next;
    logic [LENGTH_BITS-1:0] cur_col_reg, cur_col_next;
    logic [LINE_BITS-1:0]   tok_line_reg, tok_line_next;
    logic [LENGTH_BITS-1:0] tok_col_reg, tok_col_next;
    logic [LENGTH_BITS-1:0] tok_count_reg, tok_count_next;
    logic [2:0]             cand_reg, cand_next;
    logic                   halted_reg, halted_next;
    logic [ERR_BITS-1:0]    err_code_reg, err_code_next;
    logic [LINE_BITS-1:0]   err_line_reg, err_line_next;
    logic [LENGTH_BITS-1:0] err_col_reg, err_col_next;
    logic                   emit_ws_reg, emit_ws_next;

    logic                   acc;
    logic [7:0]             b;
    logic [LINE_BITS-1:0]   line_inc;
    logic [LENGTH_BITS-1:0] col_inc;
    logic [LENGTH_BITS-1:0] count_inc;
    logic [2:0]             word_hit;
    logic [2:0]             word_keep;
    logic [2:0]             word_first;

    logic   fin_valid, fin_fail;
    token_t fin_tok;
    logic   ext_ok, ext_emit;
    mode_t  ext_mode;
    token_t ext_tok;
    logic   st_valid, st_fail;
    token_t st_tok;
    mode_t  st_mode;
    logic [LENGTH_BITS-1:0] st_tok_col;
    logic [LENGTH_BITS-1:0] st_tok_count;
    token_t end_tok;
    token_t err_tok;

    assign s_axis_tready = !q_stat.full;
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign b             = s_axis_tdata;

    assign line_inc  = (&cur_line_reg) ? cur_line_reg : cur_line_reg + LINE_BITS'(1);
    assign col_inc   = (&cur_col_reg) ? cur_col_reg : cur_col_reg + LENGTH_BITS'(1);
    assign count_inc = (&tok_count_reg) ? tok_count_reg : tok_count_reg + LENGTH_BITS'(1);

    assign end_tok = mk_tok(KIND_END, cur_line_reg, cur_col_reg, '0, ERR_NONE);
    assign err_tok = mk_tok(KIND_ERROR, err_line_reg, err_col_reg, '0, err_code_reg);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            word_hit[i]   = cand_reg[i]
                            && (tok_count_reg == LENGTH_BITS'(word_len(2'(i))));
            word_keep[i]  = cand_reg[i]
                            && (tok_count_reg < LENGTH_BITS'(word_len(2'(i))))
                            && (word_char(2'(i), tok_count_reg[2:0]) == b);
            word_first[i] = (word_char(2'(i), 3'd0) == b);
        end
    end

    // close the pending token
    always_comb
    begin
        fin_valid = 1'b0;
        fin_fail  = 1'b0;
        fin_tok   = mk_tok(KIND_NUMBER, tok_line_reg, tok_col_reg, tok_count_reg, ERR_NONE);
        unique case (mode_reg)
            MODE_WS:
            begin
                fin_valid    = emit_ws_reg;
                fin_tok.kind = KIND_WHITESPACE;
            end
            MODE_ZERO, MODE_INT, MODE_FRAC, MODE_EXP:
            begin
                fin_valid = 1'b1;
            end
            MODE_MINUS:
            begin
                fin_valid = 1'b1;
                fin_fail  = 1'b1;
                fin_tok   = mk_tok(KIND_ERROR, cur_line_reg, cur_col_reg, '0, ERR_NO_INT_DIGIT);
            end
            MODE_DOT:
            begin
                fin_valid = 1'b1;
                fin_fail  = 1'b1;
                fin_tok   = mk_tok(KIND_ERROR, cur_line_reg, cur_col_reg, '0, ERR_NO_FRAC_DIGIT);
            end
            MODE_EXP_MARK, MODE_EXP_SIGN:
            begin
                fin_valid = 1'b1;
                fin_fail  = 1'b1;
                fin_tok   = mk_tok(KIND_ERROR, cur_line_reg, cur_col_reg, '0, ERR_NO_EXP_DIGIT);
            end
            MODE_WORD:
            begin
                fin_valid = 1'b1;
                priority if (word_hit[0])
                    fin_tok.kind = KIND_TRUE;
                else if (word_hit[1])
                    fin_tok.kind = KIND_FALSE;
                else if (word_hit[2])
                    fin_tok.kind = KIND_NULL;
                else
                begin
                    fin_fail = 1'b1;
                    fin_tok  = mk_tok(KIND_ERROR, cur_line_reg, cur_col_reg, '0,
                                      ERR_UNKNOWN_WORD);
                end
            end
            MODE_STR, MODE_STR_ESC:
            begin
                fin_valid = s_axis_tlast;
                fin_fail  = s_axis_tlast;
                fin_tok   = mk_tok(KIND_ERROR, tok_line_reg, tok_col_reg, '0,
                                   ERR_END_IN_STRING);
            end
            MODE_IDLE, MODE_DONE:
            begin
                fin_valid = 1'b0;
            end
            default:
            begin
                fin_valid = 1'b0;
            end
        endcase
    end

    // feed the byte to the pending token
    always_comb
    begin
        ext_ok   = 1'b1;
        ext_emit = 1'b0;
        ext_mode = mode_reg;
        ext_tok  = mk_tok(KIND_STRING, tok_line_reg, tok_col_reg, tok_count_reg, ERR_NONE);
        unique case (mode_reg)
            MODE_WS:
                ext_ok = is_space(b);
            MODE_STR:
            begin
                if (b == CH_QUOTE)
                begin
                    ext_emit = 1'b1;
                    ext_mode = MODE_IDLE;
                end
                else if (b == CH_BACKSLASH)
                    ext_mode = MODE_STR_ESC;
            end
            MODE_STR_ESC:
                ext_mode = MODE_STR;
            MODE_MINUS:
            begin
                if (b == CH_ZERO)
                    ext_mode = MODE_ZERO;
                else if (is_digit(b))
                    ext_mode = MODE_INT;
                else
                    ext_ok = 1'b0;
            end
            MODE_ZERO, MODE_INT, MODE_FRAC:
            begin
                priority if ((mode_reg != MODE_ZERO) && is_digit(b))
                    ext_mode = mode_reg;
                else if ((b == CH_DOT) && (mode_reg != MODE_FRAC))
                    ext_mode = MODE_DOT;
                else if ((b == CH_LOWER_E) || (b == CH_UPPER_E))
                    ext_mode = MODE_EXP_MARK;
                else
                    ext_ok = 1'b0;
            end
            MODE_DOT:
            begin
                ext_ok   = is_digit(b);
                ext_mode = MODE_FRAC;
            end
            MODE_EXP_MARK:
            begin
                if ((b == CH_PLUS) || (b == CH_MINUS))
                    ext_mode = MODE_EXP_SIGN;
                else if (is_digit(b))
                    ext_mode = MODE_EXP;
                else
                    ext_ok = 1'b0;
            end
            MODE_EXP_SIGN:
            begin
                ext_ok   = is_digit(b);
                ext_mode = MODE_EXP;
            end
            MODE_EXP:
                ext_ok = is_digit(b);
            MODE_WORD:
                ext_ok = is_alpha(b);
            MODE_IDLE, MODE_DONE:
                ext_ok = 1'b0;
            default:
                ext_ok = 1'b0;
        endcase
    end

    // open a new token at this byte
    always_comb
    begin
        st_valid     = 1'b0;
        st_fail      = 1'b0;
        st_tok       = mk_tok(KIND_LBRACKET, cur_line_reg, cur_col_reg, LENGTH_BITS'(1),
                              ERR_NONE);
        st_mode      = MODE_IDLE;
        st_tok_col   = cur_col_reg;
        st_tok_count = LENGTH_BITS'(1);
        priority if (b == CH_LBRACKET)
            st_valid = 1'b1;
        else if (b == CH_RBRACKET)
        begin
            st_valid    = 1'b1;
            st_tok.kind = KIND_RBRACKET;
        end
        else if (b == CH_LBRACE)
        begin
            st_valid    = 1'b1;
            st_tok.kind = KIND_LBRACE;
        end
        else if (b == CH_RBRACE)
        begin
            st_valid    = 1'b1;
            st_tok.kind = KIND_RBRACE;
        end
        else if (b == CH_COLON)
        begin
            st_valid    = 1'b1;
            st_tok.kind = KIND_COLON;
        end
        else if (b == CH_COMMA)
        begin
            st_valid    = 1'b1;
            st_tok.kind = KIND_COMMA;
        end
        else if (b == CH_QUOTE)
        begin
            st_mode      = MODE_STR;
            st_tok_col   = col_inc;
            st_tok_count = '0;
        end
        else if (b == CH_MINUS)
            st_mode = MODE_MINUS;
        else if (b == CH_ZERO)
            st_mode = MODE_ZERO;
        else if (is_space(b))
            st_mode = MODE_WS;
        else if (is_digit(b))
            st_mode = MODE_INT;
        else if (is_alpha(b))
            st_mode = MODE_WORD;
        else
        begin
            st_valid = 1'b1;
            st_fail  = 1'b1;
            st_tok   = mk_tok(KIND_ERROR, cur_line_reg, cur_col_reg, '0, ERR_UNEXPECTED);
        end
    end

    // next state
    always_comb
    begin
        mode_next      = mode_reg;
        cur_line_next  = cur_line_reg;
        cur_col_next   = cur_col_reg;
        tok_line_next  = tok_line_reg;
        tok_col_next   = tok_col_reg;
        tok_count_next = tok_count_reg;
        cand_next      = cand_reg;
        halted_next    = halted_reg;
        err_code_next  = err_code_reg;
        err_line_next  = err_line_reg;
        err_col_next   = err_col_reg;
        emit_ws_next   = cfg_we ? cfg_wdata : emit_ws_reg;
        if (acc && !halted_reg)
        begin
            if (s_axis_tlast)
            begin
                halted_next = 1'b1;
                if (fin_fail)
                begin
                    mode_next     = MODE_IDLE;
                    err_code_next = fin_tok.err;
                    err_line_next = fin_tok.line;
                    err_col_next  = fin_tok.column;
                end
                else
                    mode_next = MODE_DONE;
            end
            else
            begin
                if (ext_ok)
                begin
                    mode_next      = ext_mode;
                    tok_count_next = count_inc;
                    if (mode_reg == MODE_WORD)
                        cand_next = cand_reg & word_keep;
                end
                else if (fin_fail)
                begin
                    mode_next     = MODE_IDLE;
                    halted_next   = 1'b1;
                    err_code_next = fin_tok.err;
                    err_line_next = fin_tok.line;
                    err_col_next  = fin_tok.column;
                end
                else
                begin
                    mode_next      = st_mode;
                    tok_line_next  = cur_line_reg;
                    tok_col_next   = st_tok_col;
                    tok_count_next = st_tok_count;
                    if (st_mode == MODE_WORD)
                        cand_next = word_first;
                    if (st_fail)
                    begin
                        halted_next   = 1'b1;
                        err_code_next = st_tok.err;
                        err_line_next = st_tok.line;
                        err_col_next  = st_tok.column;
                    end
                end
                if (b == CH_NEWLINE)
                begin
                    cur_line_next = line_inc;
                    cur_col_next  = LENGTH_BITS'(1);
                end
                else
                    cur_col_next = col_inc;
            end
        end
    end

    // tokens produced by this beat
    always_comb
    begin
        q_entry.two = 1'b0;
        q_entry.t0  = end_tok;
        q_entry.t1  = end_tok;
        q_push      = 1'b0;
        if (halted_reg)
        begin
            q_push     = acc && (err_code_reg != ERR_NONE);
            q_entry.t0 = err_tok;
        end
        else if (s_axis_tlast)
        begin
            q_push = acc;
            if (fin_valid)
            begin
                q_entry.t0  = fin_tok;
                q_entry.two = !fin_fail;
            end
        end
        else if (ext_ok)
        begin
            q_push     = acc && ext_emit;
            q_entry.t0 = ext_tok;
        end
        else if (fin_valid)
        begin
            q_push      = acc;
            q_entry.t0  = fin_tok;
            q_entry.t1  = st_tok;
            q_entry.two = !fin_fail && st_valid;
        end
        else
        begin
            q_push     = acc && st_valid;
            q_entry.t0 = st_tok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            cur_line_reg  <= LINE_BITS'(1);
            cur_col_reg   <= LENGTH_BITS'(1);
            tok_line_reg  <= LINE_BITS'(1);
            tok_col_reg   <= LENGTH_BITS'(1);
            tok_count_reg <= '0;
            cand_reg      <= 3'b111;
            halted_reg    <= 1'b0;
            err_code_reg  <= ERR_NONE;
            err_line_reg  <= '0;
            err_col_reg   <= '0;
            emit_ws_reg   <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            cur_line_reg  <= cur_line_next;
            cur_col_reg   <= cur_col_next;
            tok_line_reg  <= tok_line_next;
            tok_col_reg   <= tok_col_next;
            tok_count_reg <= tok_count_next;
            cand_reg      <= cand_next;
            halted_reg    <= halted_next;
            err_code_reg  <= err_code_next;
            err_line_reg  <= err_line_next;
            err_col_reg   <= err_col_next;
            emit_ws_reg   <= emit_ws_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/jts_queue.sv =====
`default_nettype none

module jts_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire jts_pkg::entry_t      push_entry,
    input  wire logic                 pop,
    output jts_pkg::entry_t           head,
    output jts_pkg::queue_stat_t      stat
);
    import jts_pkg::*;

    entry_t               entries_reg [QDEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_BITS:0]   count_reg, count_next;

    assign head       = entries_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == (QPTR_BITS + 1)'(QDEPTH));
    assign stat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_BITS'(1) : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + (QPTR_BITS + 1)'(1);
            2'b01:   count_next = count_reg - (QPTR_BITS + 1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/jts_back.sv =====
`default_nettype none

module jts_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire jts_pkg::entry_t      head,
    input  wire jts_pkg::queue_stat_t q_stat,
    output logic                      pop,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    output jts_pkg::token_t           out_tok,
    output logic                      out_last
);
    import jts_pkg::*;

    logic   sub_reg, sub_next;
    logic   valid_reg, valid_next;
    token_t tok_reg, tok_next;
    logic   last_reg, last_next;
    logic   load;
    logic   head_last;

    assign load      = !q_stat.empty && (!valid_reg || out_ready);
    assign head_last = sub_reg || !head.two;
    assign pop       = load && head_last;

    assign out_valid = valid_reg;
    assign out_tok   = tok_reg;
    assign out_last  = last_reg;

    always_comb
    begin
        sub_next   = sub_reg;
        valid_next = valid_reg;
        tok_next   = tok_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = 1'b1;
            tok_next   = sub_reg ? head.t1 : head.t0;
            last_next  = head_last;
            sub_next   = !head_last;
        end
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        tok_reg  <= tok_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            sub_reg   <= sub_next;
            valid_reg <= valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_json_token_scanner_top.sv =====
`timescale 1ns / 100ps

module tb_json_token_scanner_top;
    import jts_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 400;
    localparam int IDLE_PCT    = 22;
    localparam int HOLD_AT     = 500;
    localparam int HOLD_CYCLES = 120;
    localparam int SETTLE      = 8;

    typedef struct packed {
        logic [7:0] value;
        logic       eot;
    } text_beat_t;

    typedef struct packed {
        logic [KIND_BITS-1:0]   kind;
        logic [LINE_BITS-1:0]   line;
        logic [LENGTH_BITS-1:0] column;
        logic [LENGTH_BITS-1:0] length;
        logic [ERR_BITS-1:0]    err;
        logic                   last;
    } token_exp_t;

    typedef enum int unsigned {
        FIN_END_CLEAN,
        FIN_END_NUMBER,
        FIN_END_IN_STRING,
        FIN_BARE_MINUS,
        FIN_BARE_DOT,
        FIN_BARE_EXP,
        FIN_BAD_WORD,
        FIN_STRAY_BYTE
    } finale_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic                   cfg_wdata = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = 8'h00;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]     m_axis_tdata;
    logic [KIND_BITS-1:0]   m_axis_tuser;
    logic                   m_axis_tlast;

    // scanner state mirror
    mode_t                  scan_st = MODE_IDLE;
    logic [LINE_BITS-1:0]   line_now = 1;
    logic [LENGTH_BITS-1:0] col_now = 1;
    logic [LINE_BITS-1:0]   tok_ln = 1;
    logic [LENGTH_BITS-1:0] tok_col = 1;
    logic [LENGTH_BITS-1:0] tok_len = 0;
    logic [2:0]             word_mask = 3'b111;
    bit                     stopped = 1'b0;
    logic [ERR_BITS-1:0]    err_hold = ERR_NONE;
    logic [LINE_BITS-1:0]   err_ln = 0;
    logic [LENGTH_BITS-1:0] err_col = 0;
    bit                     ws_on = 1'b0;

    string                  lit_words [3] = '{"true", "false", "null"};
    logic [7:0]             blank_set [6] = '{8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd32};
    logic [7:0]             punct_set [6] = '{CH_LBRACKET, CH_RBRACKET, CH_LBRACE,
                                              CH_RBRACE, CH_COLON, CH_COMMA};

    token_exp_t             step_toks [$];
    token_exp_t             pending_tokens [$];
    text_beat_t             text_beats [$];

    int                     pushed_total = 0;
    bit                     need_gap = 1'b0;
    bit                     steady = 1'b0;
    int                     beats_in = 0;
    int                     hold_left = 0;
    bit                     held_once = 1'b0;
    int                     stall_cycles = 0;
    int                     mismatch_count = 0;

    json_token_scanner_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [LENGTH_BITS-1:0] bump_len(input logic [LENGTH_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [LINE_BITS-1:0] bump_line(input logic [LINE_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic bit byte_is_blank(input logic [7:0] b);
        return (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
    endfunction

    function automatic bit byte_is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_ZERO + 8'd9);
    endfunction

    function automatic bit byte_is_letter(input logic [7:0] b);
        return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
    endfunction

    function automatic void emit_token(input logic [KIND_BITS-1:0] k,
                                       input logic [LINE_BITS-1:0] ln,
                                       input logic [LENGTH_BITS-1:0] col,
                                       input logic [LENGTH_BITS-1:0] len,
                                       input logic [ERR_BITS-1:0] code);
        if (step_toks.size() < 2)
            step_toks.push_back(token_exp_t'{kind: k, line: ln, column: col, length: len,
                                             err: code, last: 1'b0});
    endfunction

    function automatic void raise_error(input logic [ERR_BITS-1:0] code,
                                        input logic [LINE_BITS-1:0] ln,
                                        input logic [LENGTH_BITS-1:0] col);
        err_hold = code;
        err_ln = ln;
        err_col = col;
        stopped = 1'b1;
        emit_token(KIND_ERROR, ln, col, 0, code);
    endfunction

    function automatic void open_token(input mode_t m);
        scan_st = m;
        tok_ln = line_now;
        tok_col = col_now;
        tok_len = 1;
    endfunction

    function automatic void close_token(input bit at_end);
        mode_t m;
        bit    hit;
        m = scan_st;
        hit = 1'b0;
        scan_st = MODE_IDLE;
        case (m)
            MODE_WS:
                if (ws_on)
                    emit_token(KIND_WHITESPACE, tok_ln, tok_col, tok_len, ERR_NONE);
            MODE_ZERO, MODE_INT, MODE_FRAC, MODE_EXP:
                emit_token(KIND_NUMBER, tok_ln, tok_col, tok_len, ERR_NONE);
            MODE_MINUS:
                raise_error(ERR_NO_INT_DIGIT, line_now, col_now);
            MODE_DOT:
                raise_error(ERR_NO_FRAC_DIGIT, line_now, col_now);
            MODE_EXP_MARK, MODE_EXP_SIGN:
                raise_error(ERR_NO_EXP_DIGIT, line_now, col_now);
            MODE_WORD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (!hit && word_mask[i] && (tok_len == lit_words[i].len()))
                    begin
                        emit_token(KIND_TRUE + 4'(i), tok_ln, tok_col, tok_len, ERR_NONE);
                        hit = 1'b1;
                    end
                end
                if (!hit)
                    raise_error(ERR_UNKNOWN_WORD, line_now, col_now);
            end
            MODE_STR, MODE_STR_ESC:
                if (at_end)
                    raise_error(ERR_END_IN_STRING, tok_ln, tok_col);
            default:
            begin
            end
        endcase
    endfunction

    // true when the byte continues the open token
    function automatic bit extend_token(input logic [7:0] b);
        bit took;
        took = 1'b1;
        case (scan_st)
            MODE_WS:
                took = byte_is_blank(b);
            MODE_STR:
            begin
                if (b == CH_QUOTE)
                begin
                    emit_token(KIND_STRING, tok_ln, tok_col, tok_len, ERR_NONE);
                    scan_st = MODE_IDLE;
                    return 1'b1;
                end
                if (b == CH_BACKSLASH)
                    scan_st = MODE_STR_ESC;
            end
            MODE_STR_ESC:
                scan_st = MODE_STR;
            MODE_MINUS:
                if (b == CH_ZERO)
                    scan_st = MODE_ZERO;
                else if (byte_is_digit(b))
                    scan_st = MODE_INT;
                else
                    took = 1'b0;
            MODE_ZERO, MODE_INT, MODE_FRAC:
                if (!((scan_st != MODE_ZERO) && byte_is_digit(b)))
                begin
                    if ((b == CH_DOT) && (scan_st != MODE_FRAC))
                        scan_st = MODE_DOT;
                    else if ((b == CH_LOWER_E) || (b == CH_UPPER_E))
                        scan_st = MODE_EXP_MARK;
                    else
                        took = 1'b0;
                end
            MODE_DOT:
                if (byte_is_digit(b))
                    scan_st = MODE_FRAC;
                else
                    took = 1'b0;
            MODE_EXP_MARK:
                if ((b == CH_PLUS) || (b == CH_MINUS))
                    scan_st = MODE_EXP_SIGN;
                else if (byte_is_digit(b))
                    scan_st = MODE_EXP;
                else
                    took = 1'b0;
            MODE_EXP_SIGN:
                if (byte_is_digit(b))
                    scan_st = MODE_EXP;
                else
                    took = 1'b0;
            MODE_EXP:
                took = byte_is_digit(b);
            MODE_WORD:
                if (!byte_is_letter(b))
                    took = 1'b0;
                else
                begin
                    for (int i = 0; i < 3; i++)
                        if (!((tok_len < lit_words[i].len()) && (lit_words[i][tok_len] == b)))
                            word_mask[i] = 1'b0;
                end
            default:
                took = 1'b0;
        endcase
        if (took)
            tok_len = bump_len(tok_len);
        return took;
    endfunction

    function automatic void start_token(input logic [7:0] b);
        case (b)
            CH_LBRACKET: emit_token(KIND_LBRACKET, line_now, col_now, 1, ERR_NONE);
            CH_RBRACKET: emit_token(KIND_RBRACKET, line_now, col_now, 1, ERR_NONE);
            CH_LBRACE:   emit_token(KIND_LBRACE, line_now, col_now, 1, ERR_NONE);
            CH_RBRACE:   emit_token(KIND_RBRACE, line_now, col_now, 1, ERR_NONE);
            CH_COLON:    emit_token(KIND_COLON, line_now, col_now, 1, ERR_NONE);
            CH_COMMA:    emit_token(KIND_COMMA, line_now, col_now, 1, ERR_NONE);
            CH_QUOTE:
            begin
                // string position is its first body byte
                scan_st = MODE_STR;
                tok_ln = line_now;
                tok_col = bump_len(col_now);
                tok_len = 0;
            end
            CH_MINUS:    open_token(MODE_MINUS);
            CH_ZERO:     open_token(MODE_ZERO);
            default:
                if (byte_is_blank(b))
                    open_token(MODE_WS);
                else if (byte_is_digit(b))
                    open_token(MODE_INT);
                else if (byte_is_letter(b))
                begin
                    open_token(MODE_WORD);
                    word_mask = 3'b000;
                    for (int i = 0; i < 3; i++)
                        if (lit_words[i][0] == b)
                            word_mask[i] = 1'b1;
                end
                else
                    raise_error(ERR_UNEXPECTED, line_now, col_now);
        endcase
    endfunction

    function automatic void predict_tokens(input logic [7:0] b, input logic eot);
        step_toks.delete();
        if (stopped)
        begin
            if (err_hold != ERR_NONE)
                emit_token(KIND_ERROR, err_ln, err_col, 0, err_hold);
        end
        else if (eot)
        begin
            close_token(1'b1);
            if (!stopped)
            begin
                emit_token(KIND_END, line_now, col_now, 0, ERR_NONE);
                stopped = 1'b1;
                scan_st = MODE_DONE;
            end
        end
        else
        begin
            if (!extend_token(b))
            begin
                close_token(1'b0);
                if (!stopped)
                    start_token(b);
            end
            if (b == CH_NEWLINE)
            begin
                line_now = bump_line(line_now);
                col_now = 1;
            end
            else
                col_now = bump_len(col_now);
        end
        if (step_toks.size() > 0)
            step_toks[step_toks.size() - 1].last = 1'b1;
        foreach (step_toks[i])
            pending_tokens.push_back(step_toks[i]);
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("%0t mismatch: %s", $time, what);
    endtask

    task automatic check_token();
        token_exp_t got;
        token_exp_t want;
        got.kind = m_axis_tuser;
        got.line = m_axis_tdata[LINE_BITS-1:0];
        got.column = m_axis_tdata[LINE_BITS +: LENGTH_BITS];
        got.length = m_axis_tdata[LINE_BITS + LENGTH_BITS +: LENGTH_BITS];
        got.err = m_axis_tdata[LINE_BITS + 2 * LENGTH_BITS +: ERR_BITS];
        got.last = m_axis_tlast;
        if (pending_tokens.size() == 0)
            report_mismatch($sformatf("token kind %0d with none expected", got.kind));
        else
        begin
            want = pending_tokens.pop_front();
            if (got !== want)
                report_mismatch($sformatf(
                    "got kind %0d line %0d col %0d len %0d err %0d last %0b, want %0d %0d %0d %0d %0d %0b",
                    got.kind, got.line, got.column, got.length, got.err, got.last,
                    want.kind, want.line, want.column, want.length, want.err, want.last));
        end
    endtask

    // stimulus builders
    function automatic void push_byte(input logic [7:0] b, input logic eot = 1'b0);
        text_beats.push_back(text_beat_t'{value: b, eot: eot});
        pushed_total++;
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endfunction

    function automatic void push_blanks();
        repeat ($urandom_range(1, 4))
            push_byte(blank_set[$urandom_range(0, 5)]);
    endfunction

    function automatic void push_digits(input int n);
        repeat (n)
            push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    function automatic void push_separator();
        if ($urandom_range(0, 1) == 0)
            push_blanks();
        else
            push_byte(punct_set[$urandom_range(0, 5)]);
    endfunction

    function automatic void push_string();
        logic [7:0] b;
        int         n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        push_byte(CH_QUOTE);
        repeat (n)
        begin
            b = 8'($urandom_range(0, 255));
            if ((b == CH_QUOTE) || (b == CH_BACKSLASH) || ($urandom_range(0, 9) == 0))
            begin
                push_byte(CH_BACKSLASH);
                push_byte(b);
            end
            else
                push_byte(b);
        end
        push_byte(CH_QUOTE);
    endfunction

    function automatic void push_number();
        if ($urandom_range(0, 3) == 0)
            push_byte(CH_MINUS);
        if ($urandom_range(0, 3) == 0)
        begin
            push_byte(CH_ZERO);
            // digits after a lone zero open new numbers
            if ($urandom_range(0, 2) == 0)
                push_digits($urandom_range(1, 3));
        end
        else
        begin
            push_byte(CH_ZERO + 8'($urandom_range(1, 9)));
            push_digits($urandom_range(0, 3));
        end
        if ($urandom_range(0, 2) == 0)
        begin
            push_byte(CH_DOT);
            push_digits($urandom_range(1, 3));
        end
        if ($urandom_range(0, 3) == 0)
        begin
            push_byte($urandom_range(0, 1) ? CH_LOWER_E : CH_UPPER_E);
            case ($urandom_range(0, 2))
                0: push_byte(CH_PLUS);
                1: push_byte(CH_MINUS);
                default:
                begin
                end
            endcase
            push_digits($urandom_range(1, 2));
        end
    endfunction

    function automatic void add_piece();
        int pick;
        pick = $urandom_range(0, 9);
        if ((pick >= 6) && (pick <= 8) && need_gap)
            push_separator();
        case (pick)
            0, 1, 2: push_byte(punct_set[$urandom_range(0, 5)]);
            3, 4, 9: push_string();
            5:       push_blanks();
            6, 7:    push_number();
            default: push_text(lit_words[$urandom_range(0, 2)]);
        endcase
        need_gap = (pick >= 6) && (pick <= 8);
    endfunction

    function automatic void add_phase(input int n);
        int goal;
        goal = pushed_total + n;
        while (pushed_total < goal)
            add_piece();
        push_byte(CH_COMMA);
        need_gap = 1'b0;
    endfunction

    // one terminal event, then more beats to see it stick
    function automatic void add_finale();
        finale_t    pick;
        logic [7:0] b;
        int         w;
        int         k;
        pick = finale_t'($urandom_range(0, int'(FIN_STRAY_BYTE)));
        case (pick)
            FIN_END_CLEAN:
                if ($urandom_range(0, 1) == 0)
                    push_blanks();
            FIN_END_NUMBER:
                push_number();
            FIN_END_IN_STRING:
            begin
                push_byte(CH_QUOTE);
                repeat ($urandom_range(0, 5))
                begin
                    b = 8'($urandom_range(0, 255));
                    push_byte((b == CH_QUOTE || b == CH_BACKSLASH) ? 8'h41 : b);
                end
                if ($urandom_range(0, 1) == 0)
                    push_byte(CH_BACKSLASH);
            end
            FIN_BARE_MINUS:
                push_byte(CH_MINUS);
            FIN_BARE_DOT:
            begin
                push_digits(1);
                push_byte(CH_DOT);
            end
            FIN_BARE_EXP:
            begin
                push_digits(1);
                push_byte(CH_UPPER_E);
                if ($urandom_range(0, 1) == 0)
                    push_byte(CH_MINUS);
            end
            FIN_BAD_WORD:
            begin
                w = $urandom_range(0, 2);
                k = $urandom_range(1, lit_words[w].len());
                push_text(lit_words[w].substr(0, k - 1));
                if (k == lit_words[w].len())
                    push_byte(8'h61 + 8'($urandom_range(0, 25)));
            end
            default:
            begin
                if ($urandom_range(0, 1) == 0)
                    push_number();
                do
                    b = 8'($urandom_range(0, 255));
                while (byte_is_blank(b) || byte_is_digit(b) || byte_is_letter(b)
                       || (b == CH_QUOTE) || (b == CH_MINUS) || (b == CH_LBRACKET)
                       || (b == CH_RBRACKET) || (b == CH_LBRACE) || (b == CH_RBRACE)
                       || (b == CH_COLON) || (b == CH_COMMA));
                push_byte(b);
            end
        endcase
        if ((pick <= FIN_END_IN_STRING) || ($urandom_range(0, 1) == 0))
            push_byte(8'($urandom_range(0, 255)), 1'b1);
        else if (pick != FIN_STRAY_BYTE)
            push_separator();
        repeat (12)
            push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 2) == 0);
    endfunction

    task automatic write_emit_ws(input bit v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        ws_on = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while ((text_beats.size() != 0) || s_axis_tvalid || (pending_tokens.size() != 0))
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // text driver
    always @(posedge clk)
    begin
        text_beat_t nb;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_tokens(s_axis_tdata, s_axis_tlast);
                beats_in <= beats_in + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if ((text_beats.size() > 0) && (steady || ($urandom_range(0, 99) >= IDLE_PCT)))
                begin
                    nb = text_beats.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= nb.value;
                    s_axis_tlast <= nb.eot;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // token monitor and back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_token();
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!held_once && (beats_in >= HOLD_AT))
            begin
                held_once <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        write_emit_ws(1'b0);
        push_text("{\"");
        push_byte(8'h00);
        push_byte(8'hFF);
        push_text("\\\"\":-0.5E+1,[true]}");
        wait_drained();

        write_emit_ws(1'b1);
        add_phase(PHASE_ITEMS);
        wait_drained();

        write_emit_ws(1'b0);
        add_phase(PHASE_ITEMS);
        wait_drained();

        // no idling on either side
        steady = 1'b1;
        write_emit_ws(1'b1);
        add_phase(PHASE_ITEMS);
        wait_drained();
        steady = 1'b0;

        write_emit_ws($urandom_range(0, 1));
        add_phase(PHASE_ITEMS);
        add_finale();
        wait_drained();
        repeat (2 * SETTLE) @(posedge clk);

        if (pending_tokens.size() != 0)
            report_mismatch($sformatf("%0d tokens never arrived", pending_tokens.size()));
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
